@@ rtl/tle_pkg.sv @@
package tle_pkg;

    localparam int DATA_W   = 64;
    localparam int LAT_W    = 32;
    localparam int CORE_W   = 5;
    localparam int ACT_W    = 6;
    localparam int SHIFT_W  = 4;
    localparam int CFG_A_W  = 1;
    localparam int CFG_D_W  = 6;
    localparam int ALU_W    = DATA_W + 2;
    localparam int FACT_W   = LAT_W + 2;
    localparam int ITER_W   = 6;

    localparam int HUGE_LEVELS = 3;
    localparam int BASE_LEVELS = 4;

    localparam logic [CFG_A_W-1:0] CFG_ACTIVE_CORES = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_EWMA_SHIFT   = 1'b1;

    localparam logic REQ_CORE  = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    localparam logic [1:0] CNT_TOTAL  = 2'd0;
    localparam logic [1:0] CNT_LOCAL  = 2'd1;
    localparam logic [1:0] CNT_REMOTE = 2'd2;
    localparam logic [1:0] CNT_WALKS  = 2'd3;

    localparam logic SEL_HUGE = 1'b0;
    localparam logic SEL_BASE = 1'b1;

    localparam logic [ACT_W-1:0]   ACTIVE_RST = 6'd32;
    localparam logic [SHIFT_W-1:0] SHIFT_RST  = 4'd4;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CDELTA = 11'b000_0000_0010,
        S_CSUM   = 11'b000_0000_0100,
        S_LDELTA = 11'b000_0000_1000,
        S_LDIFF  = 11'b000_0001_0000,
        S_LUPD   = 11'b000_0010_0000,
        S_CMP    = 11'b000_0100_0000,
        S_MUL    = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_STORE  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic               sub;
        logic [SHIFT_W-1:0] shamt;
    } t_alu_ctl;

endpackage

@@ rtl/translation_latency_estimator_core.sv @@
// core reading: from accept, through S_CDELTA and S_CSUM, until ready again (memory read, delta, sum and write back)
// period close: averages are updated and each latency is compared and stored; when scaling applies, each
//   scaled latency runs a 34-step multiply and a 34-step divide on the shared 66-bit adder
// one item at a time; a finished word waits in the output register while new items are taken
// reset (synchronous, active low) clears the walk sum, last load counts, averages and the per-core
//   valid bits at once, and sets active_cores to 32 and ewma_shift to 4
module translation_latency_estimator_core #(
    parameter int MAX_CORES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tle_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  logic [tle_pkg::CFG_D_W-1:0]     i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_req_type,
    input  logic [tle_pkg::CORE_W-1:0]      i_core_index,
    input  logic [tle_pkg::DATA_W-1:0]      i_walk_count,
    input  logic [tle_pkg::DATA_W-1:0]      i_total_loads_count,
    input  logic [tle_pkg::DATA_W-1:0]      i_local_loads_count,
    input  logic [tle_pkg::DATA_W-1:0]      i_remote_loads_count,
    input  logic [tle_pkg::LAT_W-1:0]       i_local_latency,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tle_pkg::DATA_W-1:0]      o_latency_huge_page,
    output logic [tle_pkg::DATA_W-1:0]      o_latency_base_page,
    output logic [tle_pkg::DATA_W-1:0]      o_avg_loads,
    output logic [tle_pkg::DATA_W-1:0]      o_avg_local_loads,
    output logic [tle_pkg::DATA_W-1:0]      o_avg_remote_loads,
    output logic [tle_pkg::DATA_W-1:0]      o_avg_walks
);
    import tle_pkg::*;

    localparam int AW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam logic [8:0] MAXC = 9'(MAX_CORES);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(FACT_W - 1);

    t_state r_state;
    t_state n_state;

    logic [ACT_W-1:0]   r_active;
    logic [SHIFT_W-1:0] r_shift;

    logic [DATA_W-1:0]  r_mem [MAX_CORES];
    logic [MAX_CORES-1:0] r_vld;
    logic [DATA_W-1:0]  r_rdata;

    logic [AW-1:0]      r_core;
    logic [DATA_W-1:0]  r_walk;
    logic [DATA_W-1:0]  r_cnt [3];
    logic [LAT_W-1:0]   r_lat;

    logic [DATA_W-1:0]  r_sum;
    logic [DATA_W-1:0]  r_last [3];
    logic [DATA_W-1:0]  r_avg [4];

    logic [ALU_W-1:0]   r_tmp;
    logic [DATA_W-1:0]  r_hi;
    logic [FACT_W-1:0]  r_lo;
    logic [ITER_W-1:0]  r_iter;
    logic [1:0]         r_j;
    logic               r_sel;
    logic               r_scale;
    logic [DATA_W-1:0]  r_lat_huge;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_o_huge;
    logic [DATA_W-1:0]  r_o_base;
    logic [DATA_W-1:0]  r_o_avg [4];

    t_alu_ctl           alu_ctl;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic [ALU_W-1:0]   alu_res;

    logic               in_acc;
    logic               core_ok;
    logic               out_load;
    logic               div_ge;
    logic [FACT_W-1:0]  fact_huge;
    logic [FACT_W-1:0]  fact_base;
    logic [FACT_W-1:0]  fact;
    logic [DATA_W-1:0]  prev_walk;
    logic [DATA_W-1:0]  cnt_sel;
    logic [DATA_W-1:0]  last_sel;

    tle_alu u_alu (
        .i_ctl (alu_ctl),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign core_ok    = ({1'b0, i_core_index} < r_active) && ({4'b0, i_core_index} < MAXC);
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign fact_huge = FACT_W'(r_lat) * FACT_W'(HUGE_LEVELS);
    assign fact_base = FACT_W'(r_lat) * FACT_W'(BASE_LEVELS);
    assign fact      = (r_sel == SEL_BASE) ? fact_base : fact_huge;
    assign prev_walk = r_vld[r_core] ? r_rdata : '0;
    assign cnt_sel   = (r_j == CNT_WALKS) ? r_sum : r_cnt[r_j];
    assign last_sel  = (r_j == CNT_WALKS) ? '0 : r_last[r_j];
    assign div_ge    = !alu_res[ALU_W-1];

    always_comb begin
        alu_ctl = '{sub: 1'b0, shamt: '0};
        alu_a   = '0;
        alu_b   = '0;
        case (r_state)
            S_CDELTA: begin
                alu_ctl.sub = 1'b1;
                alu_a       = ALU_W'(r_walk);
                alu_b       = ALU_W'(prev_walk);
            end
            S_CSUM: begin
                alu_a = ALU_W'(r_sum);
                alu_b = ALU_W'(r_tmp[DATA_W-1:0]);
            end
            S_LDELTA: begin
                alu_ctl.sub = (r_j != CNT_WALKS);
                alu_a       = ALU_W'(cnt_sel);
                alu_b       = ALU_W'(last_sel);
            end
            S_LDIFF: begin
                alu_ctl.sub = 1'b1;
                alu_a       = ALU_W'(r_tmp[DATA_W-1:0]);
                alu_b       = ALU_W'(r_avg[r_j]);
            end
            S_LUPD: begin
                alu_ctl.shamt = r_shift;
                alu_a         = ALU_W'(r_avg[r_j]);
                alu_b         = r_tmp;
            end
            S_CMP: begin
                alu_ctl.sub = 1'b1;
                alu_a       = ALU_W'(r_avg[CNT_WALKS]);
                alu_b       = ALU_W'(r_avg[CNT_TOTAL]);
            end
            S_MUL: begin
                alu_a = ALU_W'(r_hi);
                alu_b = r_lo[0] ? ALU_W'(r_avg[CNT_WALKS]) : '0;
            end
            S_DIV: begin
                alu_ctl.sub = 1'b1;
                alu_a       = ALU_W'({r_hi, r_lo[FACT_W-1]});
                alu_b       = ALU_W'(r_avg[CNT_TOTAL]);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_CLOSE) begin
                        n_state = S_LDELTA;
                    end else if (core_ok) begin
                        n_state = S_CDELTA;
                    end
                end
            end
            S_CDELTA: n_state = S_CSUM;
            S_CSUM:   n_state = S_IDLE;
            S_LDELTA: n_state = S_LDIFF;
            S_LDIFF:  n_state = S_LUPD;
            S_LUPD:   n_state = (r_j == CNT_WALKS) ? S_CMP : S_LDELTA;
            S_CMP: begin
                if ((r_avg[CNT_TOTAL] != '0) && alu_res[ALU_W-1]) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_STORE;
                end
            end
            S_MUL:   n_state = (r_iter == ITER_LAST) ? S_DIV : S_MUL;
            S_DIV:   n_state = (r_iter == ITER_LAST) ? S_STORE : S_DIV;
            S_STORE: n_state = (r_sel == SEL_HUGE) ? S_CMP : S_OUT;
            S_OUT:   n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // per-core last readings
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= r_mem[AW'(i_core_index)];
        end
        if (r_state == S_CSUM) begin
            r_mem[r_core] <= r_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == S_CSUM) begin
            r_vld[r_core] <= 1'b1;
        end
    end

    // captured word and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_core   <= AW'(i_core_index);
            r_walk   <= i_walk_count;
            r_cnt[0] <= i_total_loads_count;
            r_cnt[1] <= i_local_loads_count;
            r_cnt[2] <= i_remote_loads_count;
            r_lat    <= i_local_latency;
        end
        case (r_state)
            S_CDELTA, S_LDELTA, S_LDIFF: begin
                r_tmp <= alu_res;
            end
            S_CMP: begin
                r_hi <= '0;
                r_lo <= fact;
            end
            S_MUL: begin
                r_hi <= alu_res[DATA_W:1];
                r_lo <= {alu_res[0], r_lo[FACT_W-1:1]};
            end
            S_DIV: begin
                r_hi <= div_ge ? alu_res[DATA_W-1:0] : {r_hi[DATA_W-2:0], r_lo[FACT_W-1]};
                r_lo <= {r_lo[FACT_W-2:0], div_ge};
            end
            S_STORE: begin
                if (r_sel == SEL_HUGE) begin
                    r_lat_huge <= DATA_W'(r_lo);
                end
            end
            default: begin
                r_tmp <= r_tmp;
            end
        endcase
        if (out_load) begin
            r_o_huge <= r_lat_huge;
            r_o_base <= DATA_W'(r_lo);
            r_o_avg  <= r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ACTIVE_RST;
            r_shift     <= SHIFT_RST;
            r_sum       <= '0;
            r_last      <= '{default: '0};
            r_avg       <= '{default: '0};
            r_iter      <= '0;
            r_j         <= CNT_TOTAL;
            r_sel       <= SEL_HUGE;
            r_scale     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACTIVE_CORES: r_active <= i_cfg_wdata[ACT_W-1:0];
                    CFG_EWMA_SHIFT:   r_shift  <= i_cfg_wdata[SHIFT_W-1:0];
                    default:          r_active <= r_active;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_j   <= CNT_TOTAL;
                    r_sel <= SEL_HUGE;
                end
                S_CSUM: begin
                    r_sum <= alu_res[DATA_W-1:0];
                end
                S_LDELTA: begin
                    if (r_j == CNT_WALKS) begin
                        r_sum <= '0;
                    end else begin
                        r_last[r_j] <= r_cnt[r_j];
                    end
                end
                S_LUPD: begin
                    r_avg[r_j] <= alu_res[DATA_W-1:0];
                    r_j        <= r_j + 2'd1;
                end
                S_CMP: begin
                    r_iter  <= '0;
                    r_scale <= (r_avg[CNT_TOTAL] != '0) && alu_res[ALU_W-1];
                end
                S_MUL, S_DIV: begin
                    r_iter <= (r_iter == ITER_LAST) ? '0 : r_iter + ITER_W'(1);
                end
                S_STORE: begin
                    r_sel <= SEL_BASE;
                end
                default: begin
                    r_iter <= r_iter;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_latency_huge_page = r_o_huge;
    assign o_latency_base_page = r_o_base;
    assign o_avg_loads         = r_o_avg[CNT_TOTAL];
    assign o_avg_local_loads   = r_o_avg[CNT_LOCAL];
    assign o_avg_remote_loads  = r_o_avg[CNT_REMOTE];
    assign o_avg_walks         = r_o_avg[CNT_WALKS];

    // remainder stays below the divisor through the divide
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_hi < r_avg[CNT_TOTAL]))
        else $error("divide remainder not below divisor");

    // scaled path entered only when walks are below loads
    a_scale_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_scale && (r_avg[CNT_WALKS] < r_avg[CNT_TOTAL])))
        else $error("multiply started without scaling condition");

    // written core is marked valid afterwards
    a_core_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CSUM) |=> r_vld[$past(r_core)])
        else $error("core entry not marked after write");

    // a loaded result word is presented, with the block back in idle, afterwards
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("result word not presented after load");

    // bit-serial steps stay within the factor width
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_DIV)) |-> (r_iter <= ITER_LAST))
        else $error("iteration count out of range");

endmodule

@@ rtl/tle_alu.sv @@
module tle_alu (
    input  tle_pkg::t_alu_ctl             i_ctl,
    input  logic [tle_pkg::ALU_W-1:0]     i_a,
    input  logic [tle_pkg::ALU_W-1:0]     i_b,
    output logic [tle_pkg::ALU_W-1:0]     o_res
);
    import tle_pkg::*;

    logic [ALU_W-1:0] b_sh;
    logic [ALU_W-1:0] b_op;

    // b is shifted arithmetically before the add or subtract
    assign b_sh  = ALU_W'($signed(i_b) >>> i_ctl.shamt);
    assign b_op  = i_ctl.sub ? ~b_sh : b_sh;
    assign o_res = i_a + b_op + ALU_W'(i_ctl.sub);

endmodule

@@ tb/sv/translation_latency_estimator_core_test.sv @@
`timescale 1ns / 100ps

module translation_latency_estimator_core_test;
    import tle_pkg::*;

    localparam int SETTLE    = 160;
    localparam int HOLD_LONG = 600;
    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 210;
    localparam logic [DATA_W-1:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] TOP64 = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic               req;
        logic [CORE_W-1:0]  core;
        logic [DATA_W-1:0]  walks;
        logic [DATA_W-1:0]  total;
        logic [DATA_W-1:0]  loc;
        logic [DATA_W-1:0]  rem;
        logic [LAT_W-1:0]   lat;
    } t_sample;

    typedef struct packed {
        logic [DATA_W-1:0] huge;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] ld_avg;
        logic [DATA_W-1:0] loc_avg;
        logic [DATA_W-1:0] rem_avg;
        logic [DATA_W-1:0] wlk_avg;
    } t_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [CFG_A_W-1:0]  reg_idx;
        logic [CFG_D_W-1:0]  reg_val;
        t_sample             smp;
        logic                known;
        t_result             want;
    } t_plan_row;

    localparam int DIR_ROWS = 25;
    localparam t_plan_row DIR_PLAN [DIR_ROWS] = '{
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF},
          1'b1, '{64'h2_FFFF_FFFD, 64'h3_FFFF_FFFC, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd0, MAX64, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd31, 64'h10, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd31, 64'h8, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, MAX64, TOP64, 64'd1, 32'd0},
          1'b1, '{64'd0, 64'd0, 64'h0FFF_FFFF_FFFF_FFFF, 64'h0800_0000_0000_0000,
                  64'd0, 64'd0}},
        '{ROW_CFG, CFG_EWMA_SHIFT, 6'd0, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd5, 64'd100, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, 64'd199, TOP64, 64'd1, 32'd1000},
          1'b1, '{64'd1500, 64'd2000, 64'd200, 64'd0, 64'd0, 64'd100}},
        '{ROW_CFG, CFG_ACTIVE_CORES, 6'd0, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd0, 64'd12345, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, 64'd199, TOP64, 64'd1, 32'd7},
          1'b1, '{64'd21, 64'd28, 64'd0, 64'd0, 64'd0, 64'd0}},
        '{ROW_CFG, CFG_ACTIVE_CORES, 6'd63, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd31, 64'h0123_4567_89AB_CDEF, 64'd0, 64'd0, 64'd0, 32'd0},
          1'b0, '0},
        '{ROW_CFG, CFG_ACTIVE_CORES, 6'd1, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd1, 64'hFEDC_BA98_7654_3210, 64'd0, 64'd0, 64'd0, 32'd0},
          1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0}, 1'b0, '0},
        '{ROW_CFG, CFG_EWMA_SHIFT, 6'd15, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd0, 64'h0000_0100_0000_0000, 64'd0, 64'd0, 64'd0, 32'd0},
          1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, MAX64, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555, 32'h8000_0001}, 1'b0, '0},
        '{ROW_CFG, CFG_ACTIVE_CORES, 6'd32, '0, 1'b0, '0},
        '{ROW_CFG, CFG_EWMA_SHIFT, 6'd1, '0, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CORE, 5'd7, 64'hFFFF_0000_0000_0000, 64'd0, 64'd0, 64'd0, 32'd0},
          1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, MAX64, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555, 32'h1234_5678}, 1'b0, '0},
        '{ROW_ITEM, CFG_ACTIVE_CORES, 6'd0,
          '{REQ_CLOSE, 5'd0, 64'd0, MAX64, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h5555_5555_5555_5555, 32'hFFFF_FFFF}, 1'b0, '0}
    };

    localparam logic [CFG_D_W-1:0] ACT_PLAN [PHASES]   = '{6'd32, 6'd1, 6'd63, 6'd13,
                                                           6'd32, 6'd24};
    localparam logic [CFG_D_W-1:0] SHIFT_PLAN [PHASES] = '{6'd15, 6'd0, 6'd1, 6'd4,
                                                           6'd7, 6'd2};

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  i_cfg_addr = '0;
    logic [CFG_D_W-1:0]  i_cfg_wdata = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_req_type = REQ_CORE;
    logic [CORE_W-1:0]   i_core_index = '0;
    logic [DATA_W-1:0]   i_walk_count = '0;
    logic [DATA_W-1:0]   i_total_loads_count = '0;
    logic [DATA_W-1:0]   i_local_loads_count = '0;
    logic [DATA_W-1:0]   i_remote_loads_count = '0;
    logic [LAT_W-1:0]    i_local_latency = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [DATA_W-1:0]   o_latency_huge_page;
    logic [DATA_W-1:0]   o_latency_base_page;
    logic [DATA_W-1:0]   o_avg_loads;
    logic [DATA_W-1:0]   o_avg_local_loads;
    logic [DATA_W-1:0]   o_avg_remote_loads;
    logic [DATA_W-1:0]   o_avg_walks;

    // predicted block state
    logic [DATA_W-1:0]   core_walks [32];
    logic [DATA_W-1:0]   walk_sum = '0;
    logic [DATA_W-1:0]   prev_total = '0;
    logic [DATA_W-1:0]   prev_loc = '0;
    logic [DATA_W-1:0]   prev_rem = '0;
    logic [DATA_W-1:0]   sm_loads = '0;
    logic [DATA_W-1:0]   sm_loc = '0;
    logic [DATA_W-1:0]   sm_rem = '0;
    logic [DATA_W-1:0]   sm_walks = '0;
    logic [ACT_W-1:0]    cores_enabled = ACTIVE_RST;
    logic [SHIFT_W-1:0]  ewma_k = SHIFT_RST;

    t_result             pending_estimates [$];
    int                  err_count = 0;
    bit                  tx_idle = 1'b1;
    bit                  rx_idle = 1'b1;
    int                  rx_wait = 0;
    int                  rx_hold = 0;

    // stimulus-side running counters
    logic [DATA_W-1:0]   gen_walks [32];
    logic [DATA_W-1:0]   gen_total = '0;
    logic [DATA_W-1:0]   gen_loc = '0;
    logic [DATA_W-1:0]   gen_rem = '0;

    translation_latency_estimator_core uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_req_type           (i_req_type),
        .i_core_index         (i_core_index),
        .i_walk_count         (i_walk_count),
        .i_total_loads_count  (i_total_loads_count),
        .i_local_loads_count  (i_local_loads_count),
        .i_remote_loads_count (i_remote_loads_count),
        .i_local_latency      (i_local_latency),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_latency_huge_page  (o_latency_huge_page),
        .o_latency_base_page  (o_latency_base_page),
        .o_avg_loads          (o_avg_loads),
        .o_avg_local_loads    (o_avg_local_loads),
        .o_avg_remote_loads   (o_avg_remote_loads),
        .o_avg_walks          (o_avg_walks)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] smooth(input logic [DATA_W-1:0] avg,
                                                 input logic [DATA_W-1:0] delta,
                                                 input logic [SHIFT_W-1:0] k);
        logic [2*DATA_W-1:0] acc;
        acc = ({64'd0, avg} << k) - {64'd0, avg} + {64'd0, delta};
        acc = acc >> k;
        return (acc[2*DATA_W-1:DATA_W] != '0) ? MAX64 : acc[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] scale_latency(input logic [DATA_W-1:0] fac);
        logic [2*DATA_W-1:0] prod;
        if (sm_loads == '0 || sm_walks >= sm_loads) begin
            return fac;
        end
        prod = {64'd0, sm_walks} * {64'd0, fac};
        prod = prod / {64'd0, sm_loads};
        return prod[DATA_W-1:0];
    endfunction

    function automatic void update_estimates(input t_sample s, output bit has_res,
                                             output t_result r);
        logic [DATA_W-1:0] fac;
        has_res = 1'b0;
        r = '0;
        if (s.req == REQ_CORE) begin
            if ({1'b0, s.core} < cores_enabled) begin
                walk_sum = walk_sum + (s.walks - core_walks[s.core]);
                core_walks[s.core] = s.walks;
            end
            return;
        end
        sm_loads = smooth(sm_loads, s.total - prev_total, ewma_k);
        prev_total = s.total;
        sm_loc = smooth(sm_loc, s.loc - prev_loc, ewma_k);
        prev_loc = s.loc;
        sm_rem = smooth(sm_rem, s.rem - prev_rem, ewma_k);
        prev_rem = s.rem;
        sm_walks = smooth(sm_walks, walk_sum, ewma_k);
        walk_sum = '0;
        fac = {32'd0, s.lat};
        r.huge = scale_latency(fac * DATA_W'(HUGE_LEVELS));
        r.base = scale_latency(fac * DATA_W'(BASE_LEVELS));
        r.ld_avg = sm_loads;
        r.loc_avg = sm_loc;
        r.rem_avg = sm_rem;
        r.wlk_avg = sm_walks;
        has_res = 1'b1;
    endfunction

    function automatic logic [DATA_W-1:0] spread();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        return v >> $urandom_range(8, 63);
    endfunction

    task automatic send(input t_sample s, input bit known, input t_result typed);
        int      gap;
        bit      has_res;
        t_result est;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type = s.req;
        i_core_index = s.core;
        i_walk_count = s.walks;
        i_total_loads_count = s.total;
        i_local_loads_count = s.loc;
        i_remote_loads_count = s.rem;
        i_local_latency = s.lat;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        update_estimates(s, has_res, est);
        if (has_res) begin
            pending_estimates.push_back(known ? typed : est);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_estimates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        drain();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_ACTIVE_CORES) begin
            cores_enabled = val;
        end else begin
            ewma_k = val[SHIFT_W-1:0];
        end
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
            err_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_out_ready = 1'b0;
            rx_hold--;
        end else if (rx_wait > 0) begin
            i_out_ready = 1'b0;
            rx_wait--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_estimates.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none got %h %h", $time,
                         o_latency_huge_page, o_latency_base_page);
                err_count++;
            end else begin
                want = pending_estimates.pop_front();
                check_field("latency_huge_page", want.huge, o_latency_huge_page);
                check_field("latency_base_page", want.base, o_latency_base_page);
                check_field("avg_loads", want.ld_avg, o_avg_loads);
                check_field("avg_local_loads", want.loc_avg, o_avg_local_loads);
                check_field("avg_remote_loads", want.rem_avg, o_avg_remote_loads);
                check_field("avg_walks", want.wlk_avg, o_avg_walks);
            end
            rx_wait = rx_idle ? $urandom_range(0, 7) : 0;
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int            i;
        int            ph;
        int            j;
        int            nrd;
        int            sent;
        int            lim;
        logic [CORE_W-1:0] c;
        logic [319:0]  rnd;
        t_sample       smp;
        for (i = 0; i < 32; i++) begin
            core_walks[i] = '0;
            gen_walks[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (DIR_PLAN[i].kind == ROW_CFG) begin
                write_reg(DIR_PLAN[i].reg_idx, DIR_PLAN[i].reg_val);
            end else begin
                send(DIR_PLAN[i].smp, DIR_PLAN[i].known, DIR_PLAN[i].want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_ACTIVE_CORES, ACT_PLAN[ph]);
            write_reg(CFG_EWMA_SHIFT, SHIFT_PLAN[ph]);
            tx_idle = !(ph == 3 || ph == 5);
            rx_idle = !(ph == 4 || ph == 5);
            lim = (ACT_PLAN[ph] > 32) ? 32 : int'(ACT_PLAN[ph]);
            // receiver stalls long while readings and closes keep coming
            if (ph == 2) begin
                @(posedge i_clk);
                rx_hold = HOLD_LONG;
            end
            sent = 0;
            while (sent < PHASE_LEN) begin
                if ($urandom_range(0, 49) == 0) begin
                    drain();
                end
                nrd = $urandom_range(0, 6);
                for (j = 0; j < nrd; j++) begin
                    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom};
                    smp = rnd[$bits(t_sample)-1:0];
                    smp.req = REQ_CORE;
                    if (lim < 32 && $urandom_range(0, 9) == 0) begin
                        c = CORE_W'($urandom_range(lim, 31));
                    end else begin
                        c = CORE_W'($urandom_range(0, lim - 1));
                    end
                    smp.core = c;
                    if ($urandom_range(0, 19) == 0) begin
                        smp.walks = {$urandom, $urandom};
                    end else begin
                        smp.walks = gen_walks[c] + spread();
                    end
                    gen_walks[c] = smp.walks;
                    send(smp, 1'b0, '0);
                    sent++;
                end
                rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom};
                smp = rnd[$bits(t_sample)-1:0];
                smp.req = REQ_CLOSE;
                if ($urandom_range(0, 19) != 0) begin
                    smp.total = gen_total + spread();
                    smp.loc = gen_loc + spread();
                    smp.rem = gen_rem + spread();
                end
                if ($urandom_range(0, 3) != 0) begin
                    smp.lat = $urandom_range(0, 1000);
                end
                gen_total = smp.total;
                gen_loc = smp.loc;
                gen_rem = smp.rem;
                send(smp, 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
